/* src/button_gesture_blink_controller_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture blink controller
// Concurrent assertion wrappers with clock and reset built in.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_BLINK_CONTROLLER_MACROS_SVH
`define BUTTON_GESTURE_BLINK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define BGBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgbc assertion failed");

// next-cycle implication
`define BGBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgbc assertion failed");

`endif

/* src/bgbc_pkg.sv */
// ----------------------------------------------------------------------------
// bgbc_pkg
// Shared types, constants and helper functions of the gesture controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bgbc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > REG_WIDTH) ? TIMER_WIDTH : REG_WIDTH;
    localparam int IDX_WIDTH   = 3;
    localparam int IN_WIDTH    = 8;
    localparam int OUT_WIDTH   = 8;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [REG_WIDTH-1:0]   reg_val_t;
    typedef logic [1:0]             speed_t;
    typedef logic [2:0]             gcode_t;

    typedef enum logic [IDX_WIDTH-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_WINDOW   = 3'd2,
        CFG_PERIOD_0 = 3'd3,
        CFG_PERIOD_1 = 3'd4,
        CFG_PERIOD_2 = 3'd5
    } cfg_idx_t;

    localparam reg_val_t RST_DEBOUNCE = 16'd20;
    localparam reg_val_t RST_LONG     = 16'd500;
    localparam reg_val_t RST_WINDOW   = 16'd300;
    localparam reg_val_t RST_PERIOD_0 = 16'd100;
    localparam reg_val_t RST_PERIOD_1 = 16'd250;
    localparam reg_val_t RST_PERIOD_2 = 16'd500;

    typedef enum logic [4:0] {
        G_IDLE    = 5'b00001,
        G_TIMING  = 5'b00010,
        G_LONG    = 5'b00100,
        G_WINDOW  = 5'b01000,
        G_RELEASE = 5'b10000
    } gesture_t;

    localparam gcode_t GCODE_IDLE    = 3'd0;
    localparam gcode_t GCODE_TIMING  = 3'd1;
    localparam gcode_t GCODE_LONG    = 3'd2;
    localparam gcode_t GCODE_WINDOW  = 3'd3;
    localparam gcode_t GCODE_RELEASE = 3'd4;

    typedef struct packed {
        reg_val_t debounce_ticks;
        reg_val_t long_press_ticks;
        reg_val_t click_window_ticks;
        reg_val_t blink_period_0;
        reg_val_t blink_period_1;
        reg_val_t blink_period_2;
    } cfg_t;

    typedef struct packed {
        gcode_t gesture_code;
        speed_t speed_index;
        logic   blink_active;
        logic   led_lit;
    } result_t;

    function automatic timer_t sat_inc(timer_t v);
        return (v == {TIMER_WIDTH{1'b1}}) ? v : timer_t'(v + 1'b1);
    endfunction

    function automatic logic reached(timer_t t, reg_val_t lim);
        return CMP_WIDTH'(t) >= CMP_WIDTH'(lim);
    endfunction

    function automatic gcode_t code_of(gesture_t g);
        gcode_t c;
        case (g)
            G_IDLE:    c = GCODE_IDLE;
            G_TIMING:  c = GCODE_TIMING;
            G_LONG:    c = GCODE_LONG;
            G_WINDOW:  c = GCODE_WINDOW;
            G_RELEASE: c = GCODE_RELEASE;
            default:   c = GCODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/bgbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bgbc_cfg_regs
// Configuration register file, one write beat per cycle, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bgbc_pkg::IDX_WIDTH-1:0] cfg_index,
    input  wire logic [bgbc_pkg::REG_WIDTH-1:0] cfg_data,
    output bgbc_pkg::cfg_t                      cfg
);
    import bgbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: cfg_next.debounce_ticks     = cfg_data;
                CFG_LONG:     cfg_next.long_press_ticks   = cfg_data;
                CFG_WINDOW:   cfg_next.click_window_ticks = cfg_data;
                CFG_PERIOD_0: cfg_next.blink_period_0     = cfg_data;
                CFG_PERIOD_1: cfg_next.blink_period_1     = cfg_data;
                CFG_PERIOD_2: cfg_next.blink_period_2     = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= RST_DEBOUNCE;
            cfg_reg.long_press_ticks   <= RST_LONG;
            cfg_reg.click_window_ticks <= RST_WINDOW;
            cfg_reg.blink_period_0     <= RST_PERIOD_0;
            cfg_reg.blink_period_1     <= RST_PERIOD_1;
            cfg_reg.blink_period_2     <= RST_PERIOD_2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* src/bgbc_core.sv */
// ----------------------------------------------------------------------------
// bgbc_core
// Debounce, gesture machine and blink timer; one tick per advance strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbc_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           button_down,
    input  bgbc_pkg::cfg_t      cfg,
    output bgbc_pkg::result_t   result
);
    import bgbc_pkg::*;

    gesture_t gesture_reg,        gesture_next;
    logic     stable_level_reg,   stable_level_next;
    timer_t   debounce_count_reg, debounce_count_next;
    timer_t   press_timer_reg,    press_timer_next;
    timer_t   window_timer_reg,   window_timer_next;
    timer_t   blink_timer_reg,    blink_timer_next;
    logic     blink_enable_reg,   blink_enable_next;
    speed_t   speed_sel_reg,      speed_sel_next;
    logic     blink_phase_reg,    blink_phase_next;
    logic     led_level_reg,      led_level_next;
    result_t  result_reg,         result_next;

    always_comb
    begin
        timer_t   db_inc;
        timer_t   pt_inc;
        timer_t   wt_inc;
        timer_t   bt_inc;
        reg_val_t period;
        logic     restarted;

        gesture_next        = gesture_reg;
        stable_level_next   = stable_level_reg;
        debounce_count_next = debounce_count_reg;
        press_timer_next    = press_timer_reg;
        window_timer_next   = window_timer_reg;
        blink_timer_next    = blink_timer_reg;
        blink_enable_next   = blink_enable_reg;
        speed_sel_next      = speed_sel_reg;
        blink_phase_next    = blink_phase_reg;
        led_level_next      = led_level_reg;
        restarted           = 1'b0;

        db_inc = sat_inc(debounce_count_reg);
        pt_inc = sat_inc(press_timer_reg);
        wt_inc = sat_inc(window_timer_reg);

        // debounce
        if (button_down == stable_level_reg)
        begin
            debounce_count_next = '0;
        end
        else if (reached(db_inc, cfg.debounce_ticks))
        begin
            stable_level_next   = button_down;
            debounce_count_next = '0;
        end
        else
        begin
            debounce_count_next = db_inc;
        end

        // gesture machine
        case (gesture_reg)
            G_IDLE:
            begin
                if (stable_level_next)
                begin
                    press_timer_next = '0;
                    gesture_next     = G_TIMING;
                end
            end
            G_TIMING:
            begin
                press_timer_next = pt_inc;
                if (!stable_level_next)
                begin
                    if (reached(pt_inc, cfg.long_press_ticks))
                    begin
                        led_level_next    = 1'b0;
                        blink_enable_next = 1'b0;
                        gesture_next      = G_LONG;
                    end
                    else
                    begin
                        window_timer_next = '0;
                        gesture_next      = G_WINDOW;
                    end
                end
            end
            G_LONG:
            begin
                if (!stable_level_next)
                    gesture_next = G_IDLE;
            end
            G_WINDOW:
            begin
                window_timer_next = wt_inc;
                // timeout beats a press in the same tick
                if (reached(wt_inc, cfg.click_window_ticks))
                begin
                    blink_enable_next = 1'b0;
                    led_level_next    = 1'b1;
                    gesture_next      = G_IDLE;
                end
                else if (stable_level_next)
                begin
                    if (!blink_enable_reg)
                    begin
                        blink_enable_next = 1'b1;
                        speed_sel_next    = 2'd0;
                        blink_phase_next  = 1'b0;
                    end
                    else
                    begin
                        case (speed_sel_reg)
                            2'd0:    speed_sel_next = 2'd1;
                            2'd1:    speed_sel_next = 2'd2;
                            2'd2:    speed_sel_next = 2'd0;
                            default: speed_sel_next = 2'd1;
                        endcase
                    end
                    blink_timer_next = '0;
                    restarted        = 1'b1;
                    gesture_next     = G_RELEASE;
                end
            end
            G_RELEASE:
            begin
                if (!stable_level_next)
                    gesture_next = G_IDLE;
            end
            default:
            begin
                gesture_next = G_IDLE;
            end
        endcase

        // blink timer
        case (speed_sel_next)
            2'd1:    period = cfg.blink_period_1;
            2'd2:    period = cfg.blink_period_2;
            default: period = cfg.blink_period_0;
        endcase
        bt_inc = sat_inc(blink_timer_reg);
        if (blink_enable_next && !restarted)
        begin
            if (reached(bt_inc, period))
            begin
                blink_phase_next = ~blink_phase_next;
                led_level_next   = blink_phase_next;
                blink_timer_next = '0;
            end
            else
            begin
                blink_timer_next = bt_inc;
            end
        end

        result_next.led_lit      = led_level_next;
        result_next.blink_active = blink_enable_next;
        result_next.speed_index  = speed_sel_next;
        result_next.gesture_code = code_of(gesture_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gesture_reg        <= G_IDLE;
            stable_level_reg   <= 1'b0;
            debounce_count_reg <= '0;
            press_timer_reg    <= '0;
            window_timer_reg   <= '0;
            blink_timer_reg    <= '0;
            blink_enable_reg   <= 1'b0;
            speed_sel_reg      <= 2'd0;
            blink_phase_reg    <= 1'b0;
            led_level_reg      <= 1'b1;
        end
        else if (advance)
        begin
            gesture_reg        <= gesture_next;
            stable_level_reg   <= stable_level_next;
            debounce_count_reg <= debounce_count_next;
            press_timer_reg    <= press_timer_next;
            window_timer_reg   <= window_timer_next;
            blink_timer_reg    <= blink_timer_next;
            blink_enable_reg   <= blink_enable_next;
            speed_sel_reg      <= speed_sel_next;
            blink_phase_reg    <= blink_phase_next;
            led_level_reg      <= led_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* src/button_gesture_blink_controller.sv */
// ----------------------------------------------------------------------------
// button_gesture_blink_controller
// Debounced button gesture detector driving an LED blinker, one tick a beat.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the raw button level; each
// tick yields exactly one result beat with the LED drive and status. The block
// takes one tick per clock cycle while the result side is not stalled: a tick
// is held in an input register, the core logic updates from it, and the result
// lands in an output register, where it is presented until it is taken. The
// output register decouples the sides, so a new tick is taken while a result
// still waits. Configuration writes are always ready; write them only while no
// tick is in flight.
`default_nettype none

module button_gesture_blink_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slave side
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bgbc_pkg::IN_WIDTH-1:0]  s_tdata,   // [0] button_down, [7:1] zero
    // master side
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bgbc_pkg::OUT_WIDTH-1:0]      m_tdata,   // [0] led_lit, [1] blink_active,
                                                           // [3:2] speed_index,
                                                           // [6:4] gesture_code, [7] zero
    // configuration write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bgbc_pkg::IDX_WIDTH-1:0] cfg_index,
    input  wire logic [bgbc_pkg::REG_WIDTH-1:0] cfg_data
);
    import bgbc_pkg::*;

    logic    in_valid_reg,  in_valid_next;
    logic    in_button_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_button_reg <= s_tdata[0];
    end

    bgbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgbc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .button_down (in_button_reg),
        .cfg         (cfg),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result.gesture_code, result.speed_index,
                       result.blink_active, result.led_lit};

endmodule

`default_nettype wire

/* src/bgbc_checker.sv */
// ----------------------------------------------------------------------------
// bgbc_checker
// Port-level checks on the gesture controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_blink_controller_macros.svh"

module bgbc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [bgbc_pkg::IN_WIDTH-1:0]  s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bgbc_pkg::OUT_WIDTH-1:0] m_tdata,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic [bgbc_pkg::IDX_WIDTH-1:0] cfg_index,
    input wire logic [bgbc_pkg::REG_WIDTH-1:0] cfg_data
);
    import bgbc_pkg::*;

    logic unused_inputs;
    assign unused_inputs = ^{s_tvalid, s_tready, s_tdata, cfg_valid, cfg_ready,
                             cfg_index, cfg_data};

    // a stalled result beat holds
    `BGBC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // speed selection never reaches the unused code
    `BGBC_ASSERT_IMPL(a_speed_range, clk, rst_n, m_tvalid, m_tdata[3:2] != 2'b11)

    // long held always has blinking stopped and the LED dark
    `BGBC_ASSERT_IMPL(a_long_dark, clk, rst_n, m_tvalid && (m_tdata[6:4] == GCODE_LONG), !m_tdata[1] && !m_tdata[0])

    // the gesture code is always a legal state code and bit 7 stays zero
    `BGBC_ASSERT_IMPL(a_code_range, clk, rst_n, m_tvalid, !m_tdata[7] && !(m_tdata[6] && (m_tdata[5] || m_tdata[4])))

endmodule

bind button_gesture_blink_controller bgbc_checker u_bgbc_checker (.*);

`default_nettype wire

/* test/gesture_blink_checker.sv */
// ----------------------------------------------------------------------------
// gesture_blink_checker
// Watches the tick, result and register channels of the gesture controller,
// predicts each result from the tick stream and compares it field by field.
// ----------------------------------------------------------------------------
module gesture_blink_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bgbc_pkg::IN_WIDTH-1:0]  s_tdata,    // [0] button_down
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bgbc_pkg::OUT_WIDTH-1:0] m_tdata,    // [0] led_lit, [1] blink_active,
                                                       // [3:2] speed_index,
                                                       // [6:4] gesture_code
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bgbc_pkg::IDX_WIDTH-1:0] cfg_index,
    input  logic [bgbc_pkg::REG_WIDTH-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import bgbc_pkg::*;

    reg_val_t lim_debounce;
    reg_val_t lim_long;
    reg_val_t lim_window;
    reg_val_t flash_period [3];

    gcode_t   gstate;
    logic     db_level;
    logic     flashing;
    logic     flash_phase;
    logic     led;
    speed_t   speed;
    timer_t   db_count;
    timer_t   hold_timer;
    timer_t   win_timer;
    timer_t   flash_timer;

    result_t  expected_q [$];
    result_t  want;
    result_t  got;

    function automatic timer_t bump(timer_t v);
        return (&v) ? v : timer_t'(v + 1'b1);
    endfunction

    task automatic check_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic predict_tick(input logic raw);
        logic     restarted;
        reg_val_t period;
        result_t  res;
        restarted = 1'b0;

        if (raw == db_level)
            db_count = '0;
        else
        begin
            db_count = bump(db_count);
            if (db_count >= lim_debounce)
            begin
                db_level = raw;
                db_count = '0;
            end
        end

        case (gstate)
            GCODE_IDLE:
                if (db_level)
                begin
                    hold_timer = '0;
                    gstate     = GCODE_TIMING;
                end
            GCODE_TIMING:
            begin
                hold_timer = bump(hold_timer);
                if (!db_level)
                begin
                    if (hold_timer >= lim_long)
                    begin
                        led      = 1'b0;
                        flashing = 1'b0;
                        gstate   = GCODE_LONG;
                    end
                    else
                    begin
                        win_timer = '0;
                        gstate    = GCODE_WINDOW;
                    end
                end
            end
            GCODE_LONG, GCODE_RELEASE:
                if (!db_level)
                    gstate = GCODE_IDLE;
            GCODE_WINDOW:
            begin
                win_timer = bump(win_timer);
                // timeout beats a press landing on the same tick
                if (win_timer >= lim_window)
                begin
                    flashing = 1'b0;
                    led      = 1'b1;
                    gstate   = GCODE_IDLE;
                end
                else if (db_level)
                begin
                    if (!flashing)
                    begin
                        flashing    = 1'b1;
                        speed       = '0;
                        flash_phase = 1'b0;
                    end
                    else
                        speed = speed_t'((int'(speed) + 1) % 3);
                    flash_timer = '0;
                    restarted   = 1'b1;
                    gstate      = GCODE_RELEASE;
                end
            end
            default:
                gstate = GCODE_IDLE;
        endcase

        if (flashing && !restarted)
        begin
            case (speed)
                2'd1:    period = flash_period[1];
                2'd2:    period = flash_period[2];
                default: period = flash_period[0];
            endcase
            flash_timer = bump(flash_timer);
            if (flash_timer >= period)
            begin
                flash_phase = ~flash_phase;
                led         = flash_phase;
                flash_timer = '0;
            end
        end

        res.led_lit      = led;
        res.blink_active = flashing;
        res.speed_index  = speed;
        res.gesture_code = gstate;
        expected_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_debounce    = RST_DEBOUNCE;
            lim_long        = RST_LONG;
            lim_window      = RST_WINDOW;
            flash_period[0] = RST_PERIOD_0;
            flash_period[1] = RST_PERIOD_1;
            flash_period[2] = RST_PERIOD_2;
            gstate          = GCODE_IDLE;
            db_level        = 1'b0;
            db_count        = '0;
            hold_timer      = '0;
            win_timer       = '0;
            flash_timer     = '0;
            flashing        = 1'b0;
            speed           = '0;
            flash_phase     = 1'b0;
            led             = 1'b1;
            expected_q.delete();
            mismatches      = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE: lim_debounce    = cfg_data;
                    CFG_LONG:     lim_long        = cfg_data;
                    CFG_WINDOW:   lim_window      = cfg_data;
                    CFG_PERIOD_0: flash_period[0] = cfg_data;
                    CFG_PERIOD_1: flash_period[1] = cfg_data;
                    CFG_PERIOD_2: flash_period[2] = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[0]);
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat %h with nothing expected", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    got  = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("led_lit", want.led_lit, got.led_lit);
                    check_field("blink_active", want.blink_active, got.blink_active);
                    check_field("speed_index", want.speed_index, got.speed_index);
                    check_field("gesture_code", want.gesture_code, got.gesture_code);
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

/* test/tb_button_gesture_blink_controller.sv */
// ----------------------------------------------------------------------------
// tb_button_gesture_blink_controller
// Drives debounced-button gesture sequences, clicks, long presses, bounce and
// noise through the controller under several timing settings, with bursty
// ticks and a stalling result sink; a checker module predicts every result.
// ----------------------------------------------------------------------------
module tb_button_gesture_blink_controller;
    import bgbc_pkg::*;

    localparam int STALL_LIMIT = 600;
    localparam int SPAN_CAP    = 150;
    localparam logic [IDX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [IDX_WIDTH-1:0] CFG_SPARE_B = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_WIDTH-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_WIDTH-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int burst_left  = 0;
    int ticks_sent  = 0;
    int cur_deb;
    int cur_long;
    int cur_win;

    button_gesture_blink_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gesture_blink_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** button_gesture_blink_controller: FAILED **");
            $finish;
        end
    end

    // result sink: alternates between steady, random and periodic stalls
    initial
    begin : sink
        int mode;
        int span;
        int slot;
        m_tready = 1'b0;
        slot     = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span)
            begin
                @(negedge clk);
                slot++;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ($urandom_range(0, 1) == 0);
                    default: m_tready = ((slot % 5) > 1);
                endcase
            end
        end
    end

    // all tasks start and end on a falling edge
    task automatic send_tick(input logic level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_WIDTH-1){1'b0}}, level};
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic emit(input logic level, input int n, input bit bouncy);
        repeat (n) send_tick(level ^ (bouncy && ($urandom_range(0, 9) == 0)));
    endtask

    task automatic press(input int hold, input int gap);
        emit(1'b1, hold, 1'b0);
        emit(1'b0, gap, 1'b0);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input reg_val_t val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_timing(input reg_val_t deb, input reg_val_t lng, input reg_val_t win,
                              input reg_val_t p0, input reg_val_t p1, input reg_val_t p2);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_SPARE_A, reg_val_t'($urandom));
        write_reg(CFG_PERIOD_0, p0);
        write_reg(CFG_PERIOD_1, p1);
        write_reg(CFG_PERIOD_2, p2);
        write_reg(CFG_SPARE_B, reg_val_t'($urandom));
        cfg_valid = 1'b0;
        cur_deb   = (deb > SPAN_CAP) ? SPAN_CAP : deb;
        cur_long  = (lng > SPAN_CAP) ? SPAN_CAP : lng;
        cur_win   = (win > SPAN_CAP) ? SPAN_CAP : win;
    endtask

    // mostly well-formed presses and gaps around the thresholds, some noise
    task automatic play(input int budget);
        int stop;
        int pick;
        int hold;
        int gap;
        bit bouncy;
        stop = ticks_sent + budget;
        while (ticks_sent < stop)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 12)
            begin
                bouncy = ($urandom_range(0, 3) == 0);
                if (pick < 8)
                    hold = cur_deb + $urandom_range(0, cur_long);
                else
                    hold = cur_deb + cur_long - 2 + $urandom_range(0, 4);
                if (hold < 1)
                    hold = 1;
                if (pick % 3 == 0)
                    gap = cur_deb + cur_win + $urandom_range(0, 4);
                else
                    gap = cur_deb + $urandom_range(0, cur_win + 2);
                emit(1'b1, hold, bouncy);
                emit(1'b0, gap, bouncy);
            end
            else
                repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: click, double click, speed step, long press, timeout,
        // press colliding with timeout
        set_timing(1, 3, 4, 1, 2, 3);
        press(1, 1);
        press(1, 1);
        press(1, 1);
        press(1, 1);
        press(4, 2);
        press(1, 6);
        press(1, 4);
        press(1, 1);
        drain();

        repeat (5)
        begin
            set_timing($urandom_range(1, 4), $urandom_range(2, 24), $urandom_range(2, 24),
                       $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12));
            play(90);
            drain();
        end

        set_timing(1, 1, 1, 1, 1, 1);
        play(100);
        drain();

        set_timing(1, 8, 12, 1, 16'hFFFF, 2);
        play(150);
        drain();

        set_timing(RST_DEBOUNCE, RST_LONG, RST_WINDOW, RST_PERIOD_0, RST_PERIOD_1,
                   RST_PERIOD_2);
        play(120);
        drain();

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        play(40);
        drain();

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("** button_gesture_blink_controller: PASSED **");
        else
            $display("** button_gesture_blink_controller: FAILED **");
        $finish;
    end

endmodule
